// ===== hw/rtl/padded_tile_halo_address_gen_core_assert.svh =====
// Assertion helpers for the halo address generator.
`ifndef PADDED_TILE_HALO_ADDRESS_GEN_CORE_ASSERT_SVH
`define PADDED_TILE_HALO_ADDRESS_GEN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTHA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication, matching the accept-to-result path (input register, result register).
`define PTHA_ASSERT_LAT2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ptha_pkg.sv =====
`timescale 1ns / 1ps

package ptha_pkg;

  localparam int COORD_W = 8;

  typedef enum logic [1:0] {
    REG_BEFORE  = 2'd0,
    REG_BODY    = 2'd1,
    REG_AFTER   = 2'd2,
    REG_OUTSIDE = 2'd3
  } region_t;

  typedef struct packed {
    region_t                     region;
    logic signed [COORD_W-1:0]   src;
  } axis_t;

  localparam logic [2:0] CFG_PAD_TOP_LEFT     = 3'd0;
  localparam logic [2:0] CFG_PAD_BOTTOM_RIGHT = 3'd1;
  localparam logic [2:0] CFG_TILES_DOWN       = 3'd2;
  localparam logic [2:0] CFG_TILES_ACROSS     = 3'd3;
  localparam logic [2:0] CFG_IMAGE_HEIGHT     = 3'd4;
  localparam logic [2:0] CFG_IMAGE_WIDTH      = 3'd5;
  localparam logic [2:0] CFG_ZERO_POINT       = 3'd6;

endpackage

// ===== hw/rtl/ptha_axis.sv =====
`timescale 1ns / 1ps

module ptha_axis import ptha_pkg::*; #(
  parameter int SIZE = 8
) (
  input  logic [3:0] pos,
  input  logic [3:0] pre,
  input  logic [3:0] post,
  output axis_t      axis
);

  localparam logic [COORD_W-1:0] SIZE_V = COORD_W'(SIZE);

  logic [COORD_W-1:0] pos_w;
  logic [COORD_W-1:0] pre_w;
  logic [COORD_W-1:0] post_w;
  logic [COORD_W-1:0] body_end;
  logic [COORD_W-1:0] after_end;

  assign pos_w     = COORD_W'(pos);
  assign pre_w     = COORD_W'(pre);
  assign post_w    = COORD_W'(post);
  assign body_end  = pre_w + SIZE_V;
  assign after_end = body_end + post_w;

  always_comb begin
    if (pos_w < pre_w) begin
      axis.region = REG_BEFORE;
      axis.src    = $signed(SIZE_V - pre_w + pos_w);
    end else if (pos_w < body_end) begin
      axis.region = REG_BODY;
      axis.src    = $signed(pos_w - pre_w);
    end else if (pos_w < after_end) begin
      axis.region = REG_AFTER;
      axis.src    = $signed(pos_w - body_end);
    end else begin
      axis.region = REG_OUTSIDE;
      axis.src    = '0;
    end
  end

endmodule

// ===== hw/rtl/ptha_index.sv =====
`timescale 1ns / 1ps

module ptha_index import ptha_pkg::*; #(
  parameter int BUFFER_TILES = 4096
) (
  input  logic [9:0]  channel_index,
  input  logic [6:0]  tile_row,
  input  logic [6:0]  tile_col,
  input  region_t     row_region,
  input  region_t     col_region,
  input  logic [15:0] plane,
  input  logic [7:0]  across,
  output logic        idx_ok,
  output logic [11:0] idx
);

  logic signed [8:0]  row_sel;
  logic signed [8:0]  col_sel;
  logic signed [17:0] row_term;
  logic [25:0]        chan_term;
  logic signed [27:0] sum;

  always_comb begin
    case (row_region)
      REG_BEFORE: row_sel = $signed({2'b0, tile_row}) - 9'sd1;
      REG_AFTER:  row_sel = $signed({2'b0, tile_row}) + 9'sd1;
      default:    row_sel = $signed({2'b0, tile_row});
    endcase
    case (col_region)
      REG_BEFORE: col_sel = $signed({2'b0, tile_col}) - 9'sd1;
      REG_AFTER:  col_sel = $signed({2'b0, tile_col}) + 9'sd1;
      default:    col_sel = $signed({2'b0, tile_col});
    endcase
  end

  assign row_term  = row_sel * $signed({1'b0, across});
  assign chan_term = channel_index * plane;
  assign sum       = $signed({2'b0, chan_term})
                   + $signed({{10{row_term[17]}}, row_term})
                   + $signed({{19{col_sel[8]}}, col_sel});

  assign idx_ok = !sum[27] && (sum < $signed(28'(BUFFER_TILES)));
  assign idx    = sum[11:0];

endmodule

// ===== hw/rtl/padded_tile_halo_address_gen_core.sv =====
`timescale 1ns / 1ps
// An accepted position reaches done through the input register and the result register.
// Throughput: one position per cycle; busy is low except during reset.
// Path: input register, axis classify plus the channel-by-plane and row-by-across multiplies,
// result register. The receiver cannot stall; done pulses for one cycle.
// Reset (synchronous, active high) restores register defaults and clears valids.
`include "padded_tile_halo_address_gen_core_assert.svh"

module padded_tile_halo_address_gen_core import ptha_pkg::*; #(
  parameter int TILE_HEIGHT          = 8,
  parameter int TILE_WIDTH           = 8,
  parameter int MAX_PAD_TOP_LEFT     = 3,
  parameter int MAX_PAD_BOTTOM_RIGHT = 3,
  parameter int BUFFER_TILES         = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [9:0]        channel_index,
  input  logic [6:0]        tile_row,
  input  logic [6:0]        tile_col,
  input  logic [3:0]        padded_row,
  input  logic [3:0]        padded_col,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [10:0]       cfg_data,
  output logic              done,
  output logic              in_range,
  output logic              use_fill,
  output logic signed [7:0] fill_value,
  output logic [11:0]       source_tile,
  output logic [2:0]        source_row,
  output logic [2:0]        source_col
);

  localparam logic [3:0] MAX_TL = 4'(MAX_PAD_TOP_LEFT);
  localparam logic [3:0] MAX_BR = 4'(MAX_PAD_BOTTOM_RIGHT);
  localparam logic signed [COORD_W-1:0] TH_S = COORD_W'(TILE_HEIGHT);
  localparam logic signed [COORD_W-1:0] TW_S = COORD_W'(TILE_WIDTH);

  logic [1:0]        pad_top_left;
  logic [1:0]        pad_bottom_right;
  logic [7:0]        tiles_down;
  logic [7:0]        tiles_across;
  logic [10:0]       image_height;
  logic [10:0]       image_width;
  logic signed [7:0] zero_point;
  logic [15:0]       plane;

  logic       stage_valid;
  logic [9:0] ch_q;
  logic [6:0] tr_q;
  logic [6:0] tc_q;
  logic [3:0] pr_q;
  logic [3:0] pc_q;

  logic [3:0]  ptl;
  logic [3:0]  pbr;
  axis_t       row_axis;
  axis_t       col_axis;
  logic        idx_ok;
  logic [11:0] idx;

  logic signed [14:0] row_pos;
  logic signed [14:0] col_pos;
  logic row_past, col_past;
  logic no_up, no_down, no_left, no_right;
  logic row_missing, col_missing;
  logic fill;
  logic src_ok;

  logic              in_range_next;
  logic              use_fill_next;
  logic signed [7:0] fill_value_next;
  logic [11:0]       source_tile_next;
  logic [2:0]        source_row_next;
  logic [2:0]        source_col_next;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_top_left     <= 2'd1;
      pad_bottom_right <= 2'd1;
      tiles_down       <= 8'd1;
      tiles_across     <= 8'd1;
      image_height     <= 11'd8;
      image_width      <= 11'd8;
      zero_point       <= 8'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAD_TOP_LEFT:     pad_top_left     <= cfg_data[1:0];
        CFG_PAD_BOTTOM_RIGHT: pad_bottom_right <= cfg_data[1:0];
        CFG_TILES_DOWN:       tiles_down       <= cfg_data[7:0];
        CFG_TILES_ACROSS:     tiles_across     <= cfg_data[7:0];
        CFG_IMAGE_HEIGHT:     image_height     <= cfg_data;
        CFG_IMAGE_WIDTH:      image_width      <= cfg_data;
        CFG_ZERO_POINT:       zero_point       <= $signed(cfg_data[7:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    plane <= tiles_down * tiles_across;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ch_q <= channel_index;
      tr_q <= tile_row;
      tc_q <= tile_col;
      pr_q <= padded_row;
      pc_q <= padded_col;
    end
  end

  assign ptl = (4'(pad_top_left) > MAX_TL) ? MAX_TL : 4'(pad_top_left);
  assign pbr = (4'(pad_bottom_right) > MAX_BR) ? MAX_BR : 4'(pad_bottom_right);

  ptha_axis #(.SIZE(TILE_HEIGHT)) u_row_axis (
    .pos  (pr_q),
    .pre  (ptl),
    .post (pbr),
    .axis (row_axis)
  );

  ptha_axis #(.SIZE(TILE_WIDTH)) u_col_axis (
    .pos  (pc_q),
    .pre  (ptl),
    .post (pbr),
    .axis (col_axis)
  );

  ptha_index #(.BUFFER_TILES(BUFFER_TILES)) u_index (
    .channel_index (ch_q),
    .tile_row      (tr_q),
    .tile_col      (tc_q),
    .row_region    (row_axis.region),
    .col_region    (col_axis.region),
    .plane         (plane),
    .across        (tiles_across),
    .idx_ok        (idx_ok),
    .idx           (idx)
  );

  assign row_pos = $signed(15'(tr_q) * 15'(TILE_HEIGHT))
                 + $signed({{(15-COORD_W){row_axis.src[COORD_W-1]}}, row_axis.src});
  assign col_pos = $signed(15'(tc_q) * 15'(TILE_WIDTH))
                 + $signed({{(15-COORD_W){col_axis.src[COORD_W-1]}}, col_axis.src});
  assign row_past = row_pos >= $signed({4'b0, image_height});
  assign col_past = col_pos >= $signed({4'b0, image_width});

  assign no_up    = (tr_q == 7'd0);
  assign no_down  = ({1'b0, tr_q} + 8'd1) == tiles_down;
  assign no_left  = (tc_q == 7'd0);
  assign no_right = ({1'b0, tc_q} + 8'd1) == tiles_across;

  always_comb begin
    case (row_axis.region)
      REG_BEFORE: row_missing = no_up;
      REG_AFTER:  row_missing = no_down;
      default:    row_missing = 1'b0;
    endcase
    case (col_axis.region)
      REG_BEFORE: col_missing = no_left;
      REG_AFTER:  col_missing = no_right;
      default:    col_missing = 1'b0;
    endcase
    if (row_axis.region == REG_BODY && col_axis.region == REG_BODY) begin
      fill = row_past || col_past;
    end else if (row_axis.region == REG_BODY) begin
      fill = col_missing || row_past;
    end else if (col_axis.region == REG_BODY) begin
      fill = row_missing || col_past;
    end else begin
      fill = row_missing || col_missing;
    end
  end

  assign src_ok = !row_axis.src[COORD_W-1] && (row_axis.src < TH_S)
               && !col_axis.src[COORD_W-1] && (col_axis.src < TW_S);

  always_comb begin
    in_range_next    = 1'b0;
    use_fill_next    = 1'b0;
    fill_value_next  = 8'sd0;
    source_tile_next = '0;
    source_row_next  = '0;
    source_col_next  = '0;
    if (row_axis.region == REG_OUTSIDE || col_axis.region == REG_OUTSIDE) begin
      in_range_next = 1'b0;
    end else if (fill) begin
      in_range_next   = 1'b1;
      use_fill_next   = 1'b1;
      fill_value_next = zero_point;
    end else if (src_ok && idx_ok) begin
      in_range_next    = 1'b1;
      source_tile_next = idx;
      source_row_next  = row_axis.src[2:0];
      source_col_next  = col_axis.src[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      in_range    <= in_range_next;
      use_fill    <= use_fill_next;
      fill_value  <= fill_value_next;
      source_tile <= source_tile_next;
      source_row  <= source_row_next;
      source_col  <= source_col_next;
    end
  end

  `PTHA_ASSERT_LAT2(a_latency, start && !busy, done, "accepted item produced no result")
  `PTHA_ASSERT(a_fill_in_range, done && use_fill, in_range, "fill result flagged out of range")
  `PTHA_ASSERT(a_fill_no_addr, done && use_fill, source_tile == 12'd0 && source_row == 3'd0 && source_col == 3'd0, "fill result carries an address")
  `PTHA_ASSERT(a_read_no_fill, done && !use_fill, fill_value == 8'sd0, "read result carries a fill value")
  `PTHA_ASSERT(a_oor_clear, done && !in_range, !use_fill && source_tile == 12'd0, "out-of-range result not cleared")

endmodule

// ===== test/padded_tile_halo_address_gen_core_tb.sv =====
`timescale 1ns / 1ps

module padded_tile_halo_address_gen_core_tb import ptha_pkg::*;;

  localparam int TILE_H      = 8;
  localparam int TILE_W      = 8;
  localparam int PAD_TL_MAX  = 3;
  localparam int PAD_BR_MAX  = 3;
  localparam int TILE_SLOTS  = 4096;

  typedef struct packed {
    logic              in_range;
    logic              use_fill;
    logic signed [7:0] fill_value;
    logic [11:0]       source_tile;
    logic [2:0]        source_row;
    logic [2:0]        source_col;
  } halo_source_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [9:0]        channel_index = '0;
  logic [6:0]        tile_row = '0;
  logic [6:0]        tile_col = '0;
  logic [3:0]        padded_row = '0;
  logic [3:0]        padded_col = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [10:0]       cfg_data = '0;
  logic              done;
  logic              in_range;
  logic              use_fill;
  logic signed [7:0] fill_value;
  logic [11:0]       source_tile;
  logic [2:0]        source_row;
  logic [2:0]        source_col;

  logic [1:0]  cur_pad_tl = 2'd1;
  logic [1:0]  cur_pad_br = 2'd1;
  logic [7:0]  cur_down = 8'd1;
  logic [7:0]  cur_across = 8'd1;
  logic [10:0] cur_img_h = 11'd8;
  logic [10:0] cur_img_w = 11'd8;
  logic [7:0]  cur_zero_point = 8'd0;

  halo_source_t pending_sources[$];
  halo_source_t want;
  bit gaps_on = 1'b1;
  int n_errors = 0;
  int n_items = 0;
  int n_reads = 0;
  int n_fills = 0;
  int n_rejects = 0;
  int n_settings = 1;

  padded_tile_halo_address_gen_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .channel_index (channel_index),
    .tile_row      (tile_row),
    .tile_col      (tile_col),
    .padded_row    (padded_row),
    .padded_col    (padded_col),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .in_range      (in_range),
    .use_fill      (use_fill),
    .fill_value    (fill_value),
    .source_tile   (source_tile),
    .source_row    (source_row),
    .source_col    (source_col)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic region_t classify_axis(int pos, int pre, int post, int size,
                                            output int src);
    if (pos < pre) begin
      src = size - pre + pos;
      return REG_BEFORE;
    end
    if (pos < pre + size) begin
      src = pos - pre;
      return REG_BODY;
    end
    if (pos < pre + size + post) begin
      src = pos - pre - size;
      return REG_AFTER;
    end
    src = 0;
    return REG_OUTSIDE;
  endfunction

  function automatic halo_source_t locate_source(logic [9:0] ch, logic [6:0] tr,
                                                 logic [6:0] tc, logic [3:0] pr,
                                                 logic [3:0] pc);
    halo_source_t r;
    region_t rr, cr;
    int ptl, pbr, sr, sc, dr, dc;
    bit row_past, col_past, row_missing, col_missing, zero;
    longint idx;
    r = '0;
    ptl = (int'(cur_pad_tl) > PAD_TL_MAX) ? PAD_TL_MAX : int'(cur_pad_tl);
    pbr = (int'(cur_pad_br) > PAD_BR_MAX) ? PAD_BR_MAX : int'(cur_pad_br);
    rr = classify_axis(int'(pr), ptl, pbr, TILE_H, sr);
    cr = classify_axis(int'(pc), ptl, pbr, TILE_W, sc);
    if (rr == REG_OUTSIDE || cr == REG_OUTSIDE) return r;
    dr = (rr == REG_BEFORE) ? -1 : ((rr == REG_AFTER) ? 1 : 0);
    dc = (cr == REG_BEFORE) ? -1 : ((cr == REG_AFTER) ? 1 : 0);
    row_past = (int'(tr) * TILE_H + sr) >= int'(cur_img_h);
    col_past = (int'(tc) * TILE_W + sc) >= int'(cur_img_w);
    row_missing = (dr < 0) ? (tr == 0) : ((dr > 0) ? (int'(tr) == int'(cur_down) - 1) : 1'b0);
    col_missing = (dc < 0) ? (tc == 0) : ((dc > 0) ? (int'(tc) == int'(cur_across) - 1) : 1'b0);
    if (dr == 0 && dc == 0) zero = row_past || col_past;
    else if (dr == 0) zero = col_missing || row_past;
    else if (dc == 0) zero = row_missing || col_past;
    else zero = row_missing || col_missing;
    if (zero) begin
      r.in_range = 1'b1;
      r.use_fill = 1'b1;
      r.fill_value = cur_zero_point;
      return r;
    end
    if (sr < 0 || sr >= TILE_H || sc < 0 || sc >= TILE_W) return r;
    idx = longint'(ch) * longint'(cur_down) * longint'(cur_across)
        + longint'(tr) * longint'(cur_across) + longint'(tc)
        + longint'(dr) * longint'(cur_across) + longint'(dc);
    if (idx < 0 || idx >= TILE_SLOTS) return r;
    r.in_range = 1'b1;
    r.source_tile = idx[11:0];
    r.source_row = sr[2:0];
    r.source_col = sc[2:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_sources.size() == 0) begin
        $error("result with no item outstanding");
        n_errors++;
      end else begin
        want = pending_sources.pop_front();
        if (in_range !== want.in_range) begin
          $error("in_range: expected %0d, got %0d", want.in_range, in_range);
          n_errors++;
        end
        if (use_fill !== want.use_fill) begin
          $error("use_fill: expected %0d, got %0d", want.use_fill, use_fill);
          n_errors++;
        end
        if (fill_value !== want.fill_value) begin
          $error("fill_value: expected %0d, got %0d", want.fill_value, fill_value);
          n_errors++;
        end
        if (source_tile !== want.source_tile) begin
          $error("source_tile: expected %0d, got %0d", want.source_tile, source_tile);
          n_errors++;
        end
        if (source_row !== want.source_row) begin
          $error("source_row: expected %0d, got %0d", want.source_row, source_row);
          n_errors++;
        end
        if (source_col !== want.source_col) begin
          $error("source_col: expected %0d, got %0d", want.source_col, source_col);
          n_errors++;
        end
      end
    end
  end

  task automatic send_item(int ch, int tr, int tc, int pr, int pc);
    int gap;
    halo_source_t exp_src;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    channel_index <= 10'(ch);
    tile_row <= 7'(tr);
    tile_col <= 7'(tc);
    padded_row <= 4'(pr);
    padded_col <= 4'(pc);
    do @(posedge clk); while (busy);
    exp_src = locate_source(10'(ch), 7'(tr), 7'(tc), 4'(pr), 4'(pc));
    pending_sources.push_back(exp_src);
    n_items++;
    if (!exp_src.in_range) n_rejects++;
    else if (exp_src.use_fill) n_fills++;
    else n_reads++;
  endtask

  // drop start and let every outstanding item drain before touching registers
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_sources.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PAD_TOP_LEFT:     cur_pad_tl = value[1:0];
      CFG_PAD_BOTTOM_RIGHT: cur_pad_br = value[1:0];
      CFG_TILES_DOWN:       cur_down = value[7:0];
      CFG_TILES_ACROSS:     cur_across = value[7:0];
      CFG_IMAGE_HEIGHT:     cur_img_h = value;
      CFG_IMAGE_WIDTH:      cur_img_w = value;
      CFG_ZERO_POINT:       cur_zero_point = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(int ptl, int pbr, int down, int across, int img_h, int img_w,
                              int zp);
    wait_idle();
    write_register(CFG_PAD_TOP_LEFT, 11'(ptl));
    write_register(CFG_PAD_BOTTOM_RIGHT, 11'(pbr));
    write_register(CFG_TILES_DOWN, 11'(down));
    write_register(CFG_TILES_ACROSS, 11'(across));
    write_register(CFG_IMAGE_HEIGHT, 11'(img_h));
    write_register(CFG_IMAGE_WIDTH, 11'(img_w));
    write_register(CFG_ZERO_POINT, {3'b000, 8'(zp)});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // mostly positions inside the padded tile of an existing tile, some pure noise
  task automatic send_random_position();
    int ch_hi, tr_hi, tc_hi, span;
    if ($urandom_range(0, 99) < 85) begin
      ch_hi = 4096 / (int'(cur_down) * int'(cur_across));
      if (ch_hi > 1023) ch_hi = 1023;
      tr_hi = (int'(cur_down) > 128) ? 127 : int'(cur_down) - 1;
      tc_hi = (int'(cur_across) > 128) ? 127 : int'(cur_across) - 1;
      span = int'(cur_pad_tl) + TILE_H + int'(cur_pad_br) - 1;
      send_item($urandom_range(0, ch_hi), $urandom_range(0, tr_hi), $urandom_range(0, tc_hi),
                $urandom_range(0, span), $urandom_range(0, span));
    end else begin
      send_item($urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 15), $urandom_range(0, 15));
    end
  endtask

  task automatic run_random_items(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      send_random_position();
    end
  endtask

  task automatic test_reset_layout();
    gaps_on = 1'b1;
    send_item(0, 0, 0, 0, 0);
    send_item(0, 0, 0, 0, 9);
    send_item(0, 0, 0, 9, 0);
    send_item(0, 0, 0, 9, 9);
    send_item(0, 0, 0, 0, 4);
    send_item(0, 0, 0, 5, 0);
    send_item(0, 0, 0, 1, 1);
    send_item(1023, 0, 0, 8, 8);
    send_item(0, 0, 0, 10, 3);
    send_item(0, 0, 0, 3, 15);
    send_item(0, 0, 0, 15, 15);
  endtask

  task automatic test_interior_tile();
    apply_config(3, 3, 3, 4, 20, 28, -128);
    gaps_on = 1'b0;
    send_item(0, 1, 1, 0, 0);
    send_item(0, 1, 1, 13, 13);
    send_item(0, 1, 1, 0, 6);
    send_item(0, 1, 1, 6, 13);
    send_item(0, 2, 3, 10, 10);
    send_item(0, 0, 0, 0, 5);
    send_item(0, 2, 3, 13, 13);
    send_item(341, 2, 3, 5, 5);
    send_item(340, 2, 3, 5, 5);
    send_item(1023, 127, 127, 13, 13);
  endtask

  task automatic test_max_settings();
    apply_config(3, 3, 128, 128, 1024, 1024, 127);
    run_random_items(200);
  endtask

  task automatic test_min_settings();
    apply_config(0, 0, 1, 1, 1, 1, -128);
    run_random_items(200);
  endtask

  task automatic test_random_settings();
    int down, across;
    for (int p = 0; p < 5; p++) begin
      down = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
      across = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
      apply_config($urandom_range(0, 3), $urandom_range(0, 3), down, across,
                   $urandom_range(1, (down * 8 + 8 > 1024) ? 1024 : down * 8 + 8),
                   $urandom_range(1, (across * 8 + 8 > 1024) ? 1024 : across * 8 + 8),
                   $urandom_range(0, 255));
      run_random_items(205);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_layout();
    test_interior_tile();
    test_max_settings();
    test_min_settings();
    test_random_settings();
    wait_idle();
    $display("Checked %0d positions over %0d register settings.", n_items, n_settings);
    $display("Outcomes: %0d tile reads, %0d fills, %0d rejected.", n_reads, n_fills,
             n_rejects);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
